// File: hdl/mts_pkg.sv
// ---------------------------------------------------------------------------
// mts_pkg
// Shared types, constants, sine table generator and microcode program for
// the multitone sine mixer.
// ---------------------------------------------------------------------------
package mts_pkg;

  localparam int unsigned NUM_TONES_DEF      = 6;
  localparam int unsigned PHASE_BITS_DEF     = 32;
  localparam int unsigned SINE_ADDR_BITS_DEF = 10;

  localparam int unsigned MAX_TONES  = 6;
  localparam int unsigned TONE_IDX_W = 3;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned STEP_W     = 31;
  localparam int unsigned AMP_W      = 15;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 31;

  localparam int unsigned PROD_W  = 31;
  localparam int unsigned ACC_W   = 35;
  localparam int unsigned FRAC_W  = 15;
  localparam int unsigned MAG_W   = 18;
  localparam int unsigned RECIP_K = 21;
  localparam int unsigned RECIP_W = 22;
  localparam int unsigned QP_W    = MAG_W + RECIP_W;
  localparam int unsigned QUOT_W  = QP_W - RECIP_K;

  localparam logic [FRAC_W-1:0] SAT_LIMIT = 15'h7FFF;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP0     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LAST = 4'd7;

  localparam logic [MAX_TONES-1:0] ENABLE_RESET = 6'd63;
  localparam logic [AMP_W-1:0]     AMP_RESET    = 15'd2000;
  localparam logic [STEP_W-1:0]    STEP_RESET [MAX_TONES] = '{
    31'd21426141, 31'd42852281, 31'd85704563,
    31'd171409126, 31'd342818251, 31'd685636503
  };

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;

  typedef enum logic [2:0] {
    PC_IDLE,
    PC_LOOP,
    PC_DRAIN0,
    PC_DRAIN1,
    PC_SCALE,
    PC_RECIP,
    PC_EMIT
  } pc_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_START,
    COND_TONES,
    COND_OUT,
    COND_GOTO
  } cond_t;

  typedef struct packed {
    logic  take;
    logic  clr;
    logic  rd;
    logic  scale;
    logic  recip;
    logic  emit;
    cond_t cond;
    pc_t   target;
  } uword_t;

  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    w = '{take: 1'b0, clr: 1'b0, rd: 1'b0, scale: 1'b0, recip: 1'b0, emit: 1'b0,
          cond: COND_NEXT, target: PC_IDLE};
    case (pc)
      PC_IDLE: begin
        w.take = 1'b1;
        w.clr  = 1'b1;
        w.cond = COND_START;
      end
      PC_LOOP: begin
        w.rd     = 1'b1;
        w.cond   = COND_TONES;
        w.target = PC_LOOP;
      end
      PC_DRAIN0: w.cond = COND_NEXT;
      PC_DRAIN1: w.cond = COND_NEXT;
      PC_SCALE:  w.scale = 1'b1;
      PC_RECIP:  w.recip = 1'b1;
      PC_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT;
        w.target = PC_IDLE;
      end
      default: begin
        w.cond   = COND_GOTO;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

  // ceil(2^RECIP_K / count), exact floor division for quotients below 2^MAG_W
  function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] count);
    logic [RECIP_W-1:0] r;
    case (count)
      3'd1:    r = RECIP_W'(64'd1 << RECIP_K);
      3'd2:    r = RECIP_W'(64'd1 << (RECIP_K - 1));
      3'd3:    r = RECIP_W'(((64'd1 << RECIP_K) + 64'd2) / 64'd3);
      3'd4:    r = RECIP_W'(64'd1 << (RECIP_K - 2));
      3'd5:    r = RECIP_W'(((64'd1 << RECIP_K) + 64'd4) / 64'd5);
      3'd6:    r = RECIP_W'(((64'd1 << RECIP_K) + 64'd5) / 64'd6);
      default: r = '0;
    endcase
    return r;
  endfunction

  // round(32767 * sin(pi/2 * m / 2^(addr_bits-2))), Q30 Taylor series
  function automatic logic [SAMPLE_W-1:0] sine_quarter(input int unsigned m,
                                                       input int unsigned addr_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned e;
    x  = (64'(m) * HALF_PI_Q30) >> (addr_bits - 2);
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    e  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (e > 64'd32767) begin
      e = 64'd32767;
    end
    return SAMPLE_W'(e);
  endfunction

endpackage

// File: hdl/mts_sine_rom.sv
// ---------------------------------------------------------------------------
// mts_sine_rom
// Quarter-wave sine lookup with registered read; signed 1.15 output.
// ---------------------------------------------------------------------------
module mts_sine_rom #(
  parameter int unsigned ADDR_BITS = mts_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                                  clk,
  input  logic [ADDR_BITS-1:0]                  addr,
  output logic signed [mts_pkg::SAMPLE_W-1:0]   data
);
  import mts_pkg::*;

  localparam int unsigned QLEN = 2 ** (ADDR_BITS - 2);
  localparam int unsigned MW   = ADDR_BITS - 1;

  logic [SAMPLE_W-1:0]        qtab [QLEN+1];
  logic [1:0]                 quad;
  logic [ADDR_BITS-3:0]       ofs;
  logic [MW-1:0]              m_idx;
  logic signed [SAMPLE_W-1:0] mag;
  logic signed [SAMPLE_W-1:0] data_nxt;
  logic signed [SAMPLE_W-1:0] data_r;

  for (genvar k = 0; k <= QLEN; k++) begin : g_tab
    localparam logic [SAMPLE_W-1:0] VAL = sine_quarter(k, ADDR_BITS);
    assign qtab[k] = VAL;
  end

  always_comb begin
    quad     = addr[ADDR_BITS-1 -: 2];
    ofs      = addr[ADDR_BITS-3:0];
    m_idx    = quad[0] ? (MW'(QLEN) - MW'(ofs)) : MW'(ofs);
    mag      = $signed(qtab[m_idx]);
    data_nxt = quad[1] ? -mag : mag;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// File: hdl/mts_seq.sv
// ---------------------------------------------------------------------------
// mts_seq
// Microcode sequencer: program counter over the control store in the package.
// ---------------------------------------------------------------------------
module mts_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            go,
  input  logic            tone_last,
  input  logic            out_busy,
  output mts_pkg::uword_t uword
);
  import mts_pkg::*;

  pc_t pc_r;
  pc_t pc_nxt;

  assign uword = ucode(pc_r);

  always_comb begin
    pc_nxt = pc_r;
    case (uword.cond)
      COND_NEXT:  pc_nxt = pc_t'(pc_r + 3'd1);
      COND_START: pc_nxt = go ? pc_t'(pc_r + 3'd1) : pc_r;
      COND_TONES: pc_nxt = tone_last ? pc_t'(pc_r + 3'd1) : uword.target;
      COND_OUT:   pc_nxt = out_busy ? pc_r : uword.target;
      COND_GOTO:  pc_nxt = uword.target;
      default:    pc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// File: hdl/multitone_sine_mixer.sv
// ---------------------------------------------------------------------------
// multitone_sine_mixer
// A tick request runs the microcode loop, one tone per cycle through the sine
// table, then PC_DRAIN0, PC_DRAIN1, PC_SCALE, PC_RECIP and PC_EMIT; out_valid
// is registered from PC_EMIT, which waits while the output register is held.
// Only PC_IDLE takes requests; one with tick low yields no sample. Synchronous
// reset clears phases, tone state and control and loads config defaults; a
// finished sample waits in the output register while the next request runs.
// ---------------------------------------------------------------------------
module multitone_sine_mixer #(
  parameter int unsigned NUM_TONES      = mts_pkg::NUM_TONES_DEF,
  parameter int unsigned PHASE_BITS     = mts_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_ADDR_BITS = mts_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_tick,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [mts_pkg::SAMPLE_W-1:0]    out_sample,
  output logic [mts_pkg::COUNT_W-1:0]            out_active_tones,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mts_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mts_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import mts_pkg::*;

  localparam int unsigned TONE_W = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;

  uword_t uword;
  logic   go;
  logic   tone_last;
  logic   out_busy;

  logic [MAX_TONES-1:0]  enable_r;
  logic [AMP_W-1:0]      amp_r;
  logic [STEP_W-1:0]     step_r [MAX_TONES];
  logic [PHASE_BITS-1:0] phase_r [NUM_TONES];
  logic [PHASE_BITS-1:0] phase_nxt;

  logic [TONE_W-1:0]  tone_r, tone_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               en_bit;
  logic               tag1_r, tag2_r;

  logic signed [SAMPLE_W-1:0] rom_data;
  logic signed [PROD_W-1:0]   prod_nxt, prod_r;
  logic signed [ACC_W-1:0]    acc_nxt, acc_r;
  logic [ACC_W-1:0]           acc_abs;
  logic [MAG_W-1:0]           mag_r;
  logic                       neg_r;
  logic [QP_W-1:0]            qprod_r;
  logic [QUOT_W-1:0]          quot;
  logic [FRAC_W-1:0]          sat_mag;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic [COUNT_W-1:0]         out_count_r;

  assign go        = in_valid & in_tick;
  assign tone_last = (tone_r == TONE_W'(NUM_TONES - 1));
  assign out_busy  = out_valid_r & ~out_ready;
  assign in_ready  = uword.take;
  assign cfg_ready = 1'b1;

  mts_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .tone_last (tone_last),
    .out_busy  (out_busy),
    .uword     (uword)
  );

  mts_sine_rom #(
    .ADDR_BITS (SINE_ADDR_BITS)
  ) u_rom (
    .clk  (clk),
    .addr (phase_r[tone_r][PHASE_BITS-1 -: SINE_ADDR_BITS]),
    .data (rom_data)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= ENABLE_RESET;
      amp_r    <= AMP_RESET;
      for (int i = 0; i < MAX_TONES; i++) begin
        step_r[i] <= STEP_RESET[i];
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLE:    enable_r <= cfg_data[MAX_TONES-1:0];
        REG_AMPLITUDE: amp_r    <= cfg_data[AMP_W-1:0];
        default: begin
          if (cfg_index >= REG_STEP0 && cfg_index <= REG_STEP_LAST) begin
            step_r[TONE_IDX_W'(cfg_index - REG_STEP0)] <= cfg_data[STEP_W-1:0];
          end
        end
      endcase
    end
  end

  // tone walk and phase advance
  always_comb begin
    en_bit    = enable_r[TONE_IDX_W'(tone_r)];
    phase_nxt = phase_r[tone_r] + PHASE_BITS'(step_r[TONE_IDX_W'(tone_r)]);
    tone_nxt  = tone_r;
    count_nxt = count_r;
    if (uword.clr) begin
      tone_nxt  = '0;
      count_nxt = '0;
    end else if (uword.rd) begin
      tone_nxt  = tone_r + 1'b1;
      count_nxt = count_r + COUNT_W'(en_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TONES; i++) begin
        phase_r[i] <= '0;
      end
      tone_r  <= '0;
      count_r <= '0;
      tag1_r  <= 1'b0;
      tag2_r  <= 1'b0;
    end else begin
      if (uword.rd) begin
        phase_r[tone_r] <= phase_nxt;
      end
      tone_r  <= tone_nxt;
      count_r <= count_nxt;
      tag1_r  <= uword.rd & en_bit;
      tag2_r  <= tag1_r;
    end
  end

  // multiply, accumulate, scale
  always_comb begin
    prod_nxt = PROD_W'($signed({1'b0, amp_r})) * PROD_W'(rom_data);
    acc_nxt  = acc_r;
    if (uword.clr) begin
      acc_nxt = '0;
    end else if (tag2_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
    acc_abs = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    quot    = qprod_r[QP_W-1:RECIP_K];
    sat_mag = (quot > QUOT_W'(SAT_LIMIT)) ? SAT_LIMIT : quot[FRAC_W-1:0];
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (uword.scale) begin
      mag_r <= acc_abs[FRAC_W +: MAG_W];
      neg_r <= acc_r[ACC_W-1];
    end
    if (uword.recip) begin
      qprod_r <= QP_W'(mag_r) * QP_W'(recip(count_r));
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r & ~out_ready;
    if (uword.emit && !out_busy) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (uword.emit && !out_busy) begin
      out_sample_r <= neg_r ? -$signed(SAMPLE_W'(sat_mag)) : $signed(SAMPLE_W'(sat_mag));
      out_count_r  <= count_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_active_tones = out_count_r;

endmodule
